FILE: src/rcfs_pkg.sv
package rcfs_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_HOLD_MS = 1'd1;

  localparam logic [15:0] PULSE_MS_RESET         = 16'd1000;
  localparam logic [15:0] RECOVERY_HOLD_MS_RESET = 16'd60000;

  // magic 0xAA55 arrives low byte first
  localparam logic [7:0]  MAGIC_LO      = 8'h55;
  localparam logic [7:0]  MAGIC_HI      = 8'hAA;
  localparam logic [7:0]  CMD_TYPE      = 8'd2;
  localparam logic [15:0] MIN_CMD_LEN   = 16'd3;
  localparam int          MATCH_BYTES   = 4;

  localparam logic [23:0] NAME_PWR = "PWR";
  localparam logic [23:0] NAME_RST = "RST";
  localparam logic [23:0] NAME_REC = "REC";

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_POWER    = 3'd1,
    EV_RESET    = 3'd2,
    EV_RECOVERY = 3'd3,
    EV_DROP     = 3'd4
  } ev_t;

  // one word moving from the input register to the result register
  typedef struct packed {
    logic       go;
    logic       tick;
    logic [7:0] data;
    logic       last;
  } rcfs_step_t;

  typedef struct packed {
    logic power;
    logic reset;
    logic recovery;
  } rcfs_relays_t;

endpackage

FILE: src/rcfs_parser.sv
module rcfs_parser import rcfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rcfs_step_t step,
  output ev_t        ev
);

  typedef enum logic [2:0] {
    PH_MAGIC0  = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  localparam int WIN_W = 8 * MATCH_BYTES;

  phase_t            phase_r, phase_nxt;
  logic              discard_r, discard_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       cnt_r, cnt_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [15:0]       cnt_inc;
  logic [15:0]       len_full;
  logic              byte_go;
  logic              finish;

  function automatic logic name_match(input logic [WIN_W-1:0] w, input logic [23:0] name);
    logic [7:0] b0, b1, b2, b3;
    logic       plain, digit;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    plain = (b0 == name[23:16]) && (b1 == name[15:8]) && (b2 == name[7:0]);
    digit = (b0 >= "0") && (b0 <= "9") && (b1 == name[23:16]) &&
            (b2 == name[15:8]) && (b3 == name[7:0]);
    return plain || digit;
  endfunction

  assign byte_go  = step.go && !step.tick;
  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = {step.data, len_r[7:0]};

  always_comb begin
    phase_nxt   = phase_r;
    discard_nxt = discard_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    win_nxt     = win_r;
    finish      = 1'b0;
    ev          = EV_NONE;
    if (byte_go) begin
      if (discard_r) begin
        // drop everything up to the end of the buffer
        if (step.last) begin
          discard_nxt = 1'b0;
        end
        phase_nxt = PH_MAGIC0;
      end else begin
        unique case (phase_r)
          PH_MAGIC0: begin
            if (step.data != MAGIC_LO) begin
              discard_nxt = !step.last;
              ev          = EV_DROP;
            end else begin
              phase_nxt = PH_MAGIC1;
            end
          end
          PH_MAGIC1: begin
            if (step.data != MAGIC_HI) begin
              phase_nxt   = PH_MAGIC0;
              discard_nxt = !step.last;
              ev          = EV_DROP;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_nxt  = step.data;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_nxt   = {8'h00, step.data};
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_nxt = len_full;
            win_nxt = '0;
            cnt_nxt = '0;
            // empty packet never matches a command
            phase_nxt = (len_full == 16'd0) ? PH_MAGIC0 : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (cnt_r[15:2] == 14'd0) begin
              win_nxt[{cnt_r[1:0], 3'b000} +: 8] = step.data;
            end
            cnt_nxt = cnt_inc;
            if (cnt_inc >= len_r) begin
              finish    = 1'b1;
              phase_nxt = PH_MAGIC0;
            end
          end
          default: phase_nxt = PH_MAGIC0;
        endcase
        if (finish && (type_r == CMD_TYPE) && (len_r >= MIN_CMD_LEN)) begin
          if (name_match(win_nxt, NAME_PWR)) begin
            ev = EV_POWER;
          end else if (name_match(win_nxt, NAME_RST)) begin
            ev = EV_RESET;
          end else if (name_match(win_nxt, NAME_REC)) begin
            ev = EV_RECOVERY;
          end
        end
        // buffer ended inside a frame
        if (step.last && (phase_nxt != PH_MAGIC0)) begin
          phase_nxt = PH_MAGIC0;
          ev        = EV_DROP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC0;
      discard_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    win_r  <= win_nxt;
  end

endmodule

FILE: src/rcfs_relay_timers.sv
module rcfs_relay_timers import rcfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  rcfs_step_t            step,
  input  ev_t                   ev,
  output rcfs_relays_t          relays_nxt
);

  typedef enum logic [1:0] {
    RS_IDLE  = 2'd0,
    RS_RESET = 2'd1,
    RS_HOLD  = 2'd2
  } rec_step_t;

  logic [15:0]  pulse_ms_r;
  logic [15:0]  recovery_hold_ms_r;
  logic [15:0]  pwr_timer_r, pwr_timer_nxt;
  logic [15:0]  rst_timer_r, rst_timer_nxt;
  logic [15:0]  rec_timer_r, rec_timer_nxt;
  logic [15:0]  rec_timer_dec;
  rec_step_t    rec_step_r, rec_step_nxt;
  rcfs_relays_t relays_r;
  logic [15:0]  pulse_len;
  logic [15:0]  hold_len;

  // a zero setting acts as one tick
  assign pulse_len     = (pulse_ms_r == 16'd0) ? 16'd1 : pulse_ms_r;
  assign hold_len      = (recovery_hold_ms_r == 16'd0) ? 16'd1 : recovery_hold_ms_r;
  assign rec_timer_dec = (rec_timer_r != 16'd0) ? rec_timer_r - 16'd1 : rec_timer_r;

  always_comb begin
    pwr_timer_nxt = pwr_timer_r;
    rst_timer_nxt = rst_timer_r;
    rec_timer_nxt = rec_timer_r;
    rec_step_nxt  = rec_step_r;
    relays_nxt    = relays_r;
    if (step.go && step.tick) begin
      if (pwr_timer_r != 16'd0) begin
        pwr_timer_nxt = pwr_timer_r - 16'd1;
        if (pwr_timer_r == 16'd1) begin
          relays_nxt.power = 1'b0;
        end
      end
      if (rst_timer_r != 16'd0) begin
        rst_timer_nxt = rst_timer_r - 16'd1;
        if (rst_timer_r == 16'd1) begin
          relays_nxt.reset = 1'b0;
        end
      end
      case (rec_step_r)
        RS_RESET: begin
          rec_timer_nxt = rec_timer_dec;
          if (rec_timer_dec == 16'd0) begin
            // release reset, keep recovery for the hold time
            relays_nxt.reset = 1'b0;
            rec_timer_nxt    = hold_len;
            rec_step_nxt     = RS_HOLD;
          end
        end
        RS_HOLD: begin
          rec_timer_nxt = rec_timer_dec;
          if (rec_timer_dec == 16'd0) begin
            relays_nxt.recovery = 1'b0;
            rec_step_nxt        = RS_IDLE;
          end
        end
        default: ;
      endcase
    end else if (step.go) begin
      case (ev)
        EV_POWER: begin
          relays_nxt.power = 1'b1;
          pwr_timer_nxt    = pulse_len;
        end
        EV_RESET: begin
          relays_nxt.reset = 1'b1;
          rst_timer_nxt    = pulse_len;
        end
        EV_RECOVERY: begin
          relays_nxt.reset    = 1'b1;
          relays_nxt.recovery = 1'b1;
          rec_timer_nxt       = pulse_len;
          rec_step_nxt        = RS_RESET;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ms_r         <= PULSE_MS_RESET;
      recovery_hold_ms_r <= RECOVERY_HOLD_MS_RESET;
      pwr_timer_r        <= '0;
      rst_timer_r        <= '0;
      rec_timer_r        <= '0;
      rec_step_r         <= RS_IDLE;
      relays_r           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PULSE_MS:         pulse_ms_r         <= cfg_wdata;
          REG_RECOVERY_HOLD_MS: recovery_hold_ms_r <= cfg_wdata;
          default: ;
        endcase
      end
      pwr_timer_r <= pwr_timer_nxt;
      rst_timer_r <= rst_timer_nxt;
      rec_timer_r <= rec_timer_nxt;
      rec_step_r  <= rec_step_nxt;
      relays_r    <= relays_nxt;
    end
  end

endmodule

FILE: src/relay_command_frame_sequencer_top.sv
// channel  | ports                                        | direction
// input    | in_valid, in_stall, in_command, in_data_byte, | words in
//          | in_last_of_buffer                            |
// result   | out_valid, out_stall, out_relay_*, out_event_res | words out
// config   | cfg_we, cfg_index, cfg_wdata                 | register writes
//
// One word per cycle while out_stall is low; a word enters the input register,
// then the parser and relay timers update as it moves into the result register.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to
// magic search, clears timers and relays and loads the two default settings.
// out_stall holds the result register; the input register still advances
// whenever the result register is empty or being taken.
module relay_command_frame_sequencer_top import rcfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_of_buffer,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_relay_power,
  output logic                  out_relay_reset,
  output logic                  out_relay_recovery,
  output logic [2:0]            out_event_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic         s1_valid_r;
  logic         s1_command_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         out_valid_r;
  rcfs_relays_t out_relays_r;
  ev_t          out_event_r;
  logic         out_free;
  logic         adv;
  logic         in_take;
  rcfs_step_t   step;
  ev_t          parser_ev;
  rcfs_relays_t relays_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign step.go   = adv;
  assign step.tick = s1_command_r;
  assign step.data = s1_byte_r;
  assign step.last = s1_last_r;

  rcfs_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ev    (parser_ev)
  );

  rcfs_relay_timers u_timers (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step       (step),
    .ev         (parser_ev),
    .relays_nxt (relays_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r <= in_command;
      s1_byte_r    <= in_data_byte;
      s1_last_r    <= in_last_of_buffer;
    end
    if (adv) begin
      out_relays_r <= relays_nxt;
      out_event_r  <= parser_ev;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_relay_power    = out_relays_r.power;
  assign out_relay_reset    = out_relays_r.reset;
  assign out_relay_recovery = out_relays_r.recovery;
  assign out_event_res      = out_event_r;

  // a tick never reports an event
  a_tick_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_command_r |=> out_event_res == EV_NONE)
    else $error("tick produced an event");

  a_power_on: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (parser_ev == EV_POWER) |=> out_relay_power)
    else $error("power command did not energize power relay");

  a_recovery_on: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (parser_ev == EV_RECOVERY) |=> out_relay_recovery && out_relay_reset)
    else $error("recovery command did not energize recovery and reset relays");

  a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("word left input register without a result");

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import rcfs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [2:0] {
    SEEK_LO, SEEK_HI, GET_TYPE, GET_LEN_LO, GET_LEN_HI, GET_BODY
  } frame_phase_t;

  typedef enum logic [1:0] {REC_IDLE, REC_RESET_ON, REC_HOLD} rec_phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data;
    logic       last;
  } rx_word_t;

  typedef struct packed {
    logic power;
    logic reset;
    logic recovery;
    ev_t  ev;
  } relay_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = 1'b0;
  logic [7:0]            in_data_byte = 8'd0;
  logic                  in_last_of_buffer = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_relay_power;
  logic                  out_relay_reset;
  logic                  out_relay_recovery;
  logic [2:0]            out_event_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  relay_command_frame_sequencer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_last_of_buffer  (in_last_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_relay_power    (out_relay_power),
    .out_relay_reset    (out_relay_reset),
    .out_relay_recovery (out_relay_recovery),
    .out_event_res      (out_event_res),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rx_word_t    pending_words[$];
  relay_word_t expected_words[$];
  logic [7:0]  body_q[$];
  rx_word_t    drive_word;
  bit          sent_taken = 0;
  bit          no_gaps = 0;
  bit          rx_hold_go = 0;
  int          rx_hold_left = 0;
  int          pushed = 0;
  int          words_seen = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;

  // predictor state
  logic [15:0]  pulse_set;
  logic [15:0]  hold_set;
  frame_phase_t fr_phase;
  logic [7:0]   fr_type;
  logic [15:0]  fr_len;
  logic [15:0]  fr_count;
  logic [31:0]  fr_window;
  bit           skip_buf;
  logic [15:0]  pwr_left;
  logic [15:0]  rst_left;
  rec_phase_t   rec_phase;
  logic [16:0]  rec_left;
  logic         pwr_on;
  logic         rst_on;
  logic         rec_on;

  function automatic logic [15:0] floor_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // name at offset 0, or at offset 1 behind one decimal digit
  function automatic logic names_match(input logic [31:0] w, input logic [23:0] nm);
    logic [7:0] b0, b1, b2, b3;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    if (b0 == nm[23:16] && b1 == nm[15:8] && b2 == nm[7:0])
      return 1'b1;
    return (b0 >= "0" && b0 <= "9" && b1 == nm[23:16] && b2 == nm[15:8] &&
            b3 == nm[7:0]);
  endfunction

  function ev_t close_frame();
    if (fr_type != CMD_TYPE || fr_len < MIN_CMD_LEN)
      return EV_NONE;
    if (names_match(fr_window, NAME_PWR)) begin
      pwr_on = 1'b1;
      pwr_left = floor_one(pulse_set);
      return EV_POWER;
    end
    if (names_match(fr_window, NAME_RST)) begin
      rst_on = 1'b1;
      rst_left = floor_one(pulse_set);
      return EV_RESET;
    end
    if (names_match(fr_window, NAME_REC)) begin
      rec_on = 1'b1;
      rst_on = 1'b1;
      rec_left = {1'b0, floor_one(pulse_set)};
      rec_phase = REC_RESET_ON;
      return EV_RECOVERY;
    end
    return EV_NONE;
  endfunction

  function void advance_timers();
    if (pwr_left != 16'd0) begin
      pwr_left = pwr_left - 16'd1;
      if (pwr_left == 16'd0) pwr_on = 1'b0;
    end
    if (rst_left != 16'd0) begin
      rst_left = rst_left - 16'd1;
      if (rst_left == 16'd0) rst_on = 1'b0;
    end
    if (rec_phase == REC_RESET_ON) begin
      if (rec_left != 17'd0) rec_left = rec_left - 17'd1;
      if (rec_left == 17'd0) begin
        rst_on = 1'b0;
        rec_left = {1'b0, floor_one(hold_set)};
        rec_phase = REC_HOLD;
      end
    end else if (rec_phase == REC_HOLD) begin
      if (rec_left != 17'd0) rec_left = rec_left - 17'd1;
      if (rec_left == 17'd0) begin
        rec_on = 1'b0;
        rec_phase = REC_IDLE;
      end
    end
  endfunction

  function ev_t take_byte(input logic [7:0] b, input logic last);
    ev_t ev;
    ev = EV_NONE;
    if (skip_buf) begin
      if (last) skip_buf = 0;
      fr_phase = SEEK_LO;
      return EV_NONE;
    end
    case (fr_phase)
      SEEK_LO, SEEK_HI: begin
        if (b != ((fr_phase == SEEK_LO) ? MAGIC_LO : MAGIC_HI)) begin
          fr_phase = SEEK_LO;
          skip_buf = !last;
          return EV_DROP;
        end
        fr_phase = (fr_phase == SEEK_LO) ? SEEK_HI : GET_TYPE;
      end
      GET_TYPE: begin
        fr_type = b;
        fr_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        fr_len = {8'd0, b};
        fr_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        fr_len[15:8] = b;
        fr_window = 32'd0;
        fr_count = 16'd0;
        if (fr_len == 16'd0) begin
          ev = close_frame();
          fr_phase = SEEK_LO;
        end else begin
          fr_phase = GET_BODY;
        end
      end
      default: begin
        if (fr_count < MATCH_BYTES) fr_window[8*fr_count +: 8] = b;
        fr_count = fr_count + 16'd1;
        if (fr_count >= fr_len) begin
          ev = close_frame();
          fr_phase = SEEK_LO;
        end
      end
    endcase
    if (last && fr_phase != SEEK_LO) begin
      fr_phase = SEEK_LO;
      ev = EV_DROP;
    end
    return ev;
  endfunction

  function relay_word_t predict_word(input rx_word_t w);
    relay_word_t r;
    ev_t ev;
    if (w.command) begin
      advance_timers();
      ev = EV_NONE;
    end else begin
      ev = take_byte(w.data, w.last);
    end
    r.power = pwr_on;
    r.reset = rst_on;
    r.recovery = rec_on;
    r.ev = ev;
    return r;
  endfunction

  task report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at word %0d: got %0d, want %0d",
             field, words_seen, got, want);
    mismatches++;
  endtask

  // check results, then log the accepted input word
  always @(posedge clk) begin
    relay_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", int'(out_event_res), 0);
        end else begin
          want = expected_words.pop_front();
          if (out_relay_power !== want.power)
            report_mismatch("relay_power", int'(out_relay_power), int'(want.power));
          if (out_relay_reset !== want.reset)
            report_mismatch("relay_reset", int'(out_relay_reset), int'(want.reset));
          if (out_relay_recovery !== want.recovery)
            report_mismatch("relay_recovery", int'(out_relay_recovery),
                            int'(want.recovery));
          if (out_event_res !== want.ev)
            report_mismatch("event_res", int'(out_event_res), int'(want.ev));
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        drive_word.command = in_command;
        drive_word.data = in_data_byte;
        drive_word.last = in_last_of_buffer;
        expected_words.push_back(predict_word(drive_word));
        sent_taken = 1;
      end
    end
  end

  // sender: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    rx_word_t nxt;
    if (!in_valid || sent_taken) begin
      sent_taken = 0;
      if (pending_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 32)) begin
        nxt = pending_words.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.command;
        in_data_byte <= nxt.data;
        in_last_of_buffer <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold_go) begin
      rx_hold_go = 0;
      rx_hold_left = 400;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  task push_word(input logic cmd, input logic [7:0] d, input logic last);
    rx_word_t w;
    w.command = cmd;
    w.data = d;
    w.last = last;
    pending_words.push_back(w);
    pushed++;
  endtask

  task push_ticks(input int n);
    repeat (n) push_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task make_cmd_body(input int which, input bit digit, input int extra);
    logic [23:0] nm;
    body_q.delete();
    if (digit) body_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    case (which)
      0: nm = NAME_PWR;
      1: nm = NAME_RST;
      2: nm = NAME_REC;
      default: nm = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    body_q.push_back(nm[23:16]);
    body_q.push_back(nm[15:8]);
    body_q.push_back(nm[7:0]);
    repeat (extra) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task prepend_header(input logic [7:0] t, input logic [15:0] len);
    body_q.push_front(len[15:8]);
    body_q.push_front(len[7:0]);
    body_q.push_front(t);
    body_q.push_front(MAGIC_HI);
    body_q.push_front(MAGIC_LO);
  endtask

  task emit_body(input int count, input bit end_buf);
    for (int i = 0; i < count; i++)
      push_word(1'b0, body_q[i], end_buf && (i == count - 1));
  endtask

  task push_frame(input logic [7:0] t, input logic [15:0] len, input bit end_buf);
    prepend_header(t, len);
    emit_body(body_q.size(), end_buf);
  endtask

  task push_bad_magic();
    logic [7:0] b;
    if ($urandom_range(0, 1)) begin
      do b = 8'($urandom_range(0, 255)); while (b == MAGIC_LO);
    end else begin
      push_word(1'b0, MAGIC_LO, 1'b0);
      do b = 8'($urandom_range(0, 255)); while (b == MAGIC_HI);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_word(1'b0, b, 1'b1);
    end else begin
      push_word(1'b0, b, 1'b0);
      repeat ($urandom_range(0, 4)) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task random_traffic(input int n);
    int stop;
    int kind;
    logic [7:0] t;
    logic [15:0] len;
    stop = pushed + n;
    while (pushed < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        make_cmd_body($urandom_range(0, 3), $urandom_range(0, 2) == 0, $urandom_range(0, 3));
        t = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CMD_TYPE;
        push_frame(t, 16'(body_q.size()), $urandom_range(0, 9) < 7);
      end else if (kind < 70) begin
        push_ticks($urandom_range(1, 8));
      end else if (kind < 78) begin
        push_bad_magic();
      end else if (kind < 88) begin
        // cut the frame short with the end of the buffer
        make_cmd_body($urandom_range(0, 3), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 2));
        if ($urandom_range(0, 1))
          len = 16'($urandom_range(0, 16'hFFFF));
        else
          len = 16'(body_q.size() + $urandom_range(1, 300));
        prepend_header(CMD_TYPE, len);
        emit_body($urandom_range(1, body_q.size()), 1'b1);
      end else if (kind < 94) begin
        body_q.delete();
        repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom_range(0, 255)));
        t = ($urandom_range(0, 2) == 0) ? CMD_TYPE : 8'($urandom_range(0, 255));
        if (t == CMD_TYPE && body_q.size() > 2) void'(body_q.pop_back());
        push_frame(t, 16'(body_q.size()), 1'b1);
      end else begin
        push_word(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task wait_drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PULSE_MS:         pulse_set = v;
      REG_RECOVERY_HOLD_MS: hold_set = v;
      default: ;
    endcase
  endtask

  task set_timing(input logic [15:0] p, input logic [15:0] h);
    set_reg(REG_PULSE_MS, p);
    set_reg(REG_RECOVERY_HOLD_MS, h);
    @(posedge clk);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("relay_command_frame_sequencer_top verification failed");
    $finish;
  end

  initial begin
    pulse_set = PULSE_MS_RESET;
    hold_set = RECOVERY_HOLD_MS_RESET;
    fr_phase = SEEK_LO;
    fr_type = 8'd0;
    fr_len = 16'd0;
    fr_count = 16'd0;
    fr_window = 32'd0;
    skip_buf = 0;
    pwr_left = 16'd0;
    rst_left = 16'd0;
    rec_phase = REC_IDLE;
    rec_left = 17'd0;
    pwr_on = 1'b0;
    rst_on = 1'b0;
    rec_on = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default timing straight out of reset
    random_traffic(100);
    wait_drain();

    // directed: each command, digit prefix, tick release, bad magic, truncation
    set_timing(16'd3, 16'd4);
    make_cmd_body(0, 0, 0);
    push_frame(CMD_TYPE, 16'd3, 1'b1);
    push_ticks(3);
    make_cmd_body(1, 1, 0);
    push_frame(CMD_TYPE, 16'd4, 1'b0);
    make_cmd_body(2, 0, 1);
    push_frame(CMD_TYPE, 16'd4, 1'b1);
    push_ticks(8);
    body_q.delete();
    push_frame(CMD_TYPE, 16'd0, 1'b1);
    push_word(1'b0, 8'h00, 1'b0);
    push_word(1'b0, 8'hFF, 1'b0);
    push_word(1'b0, MAGIC_LO, 1'b1);
    make_cmd_body(0, 0, 0);
    prepend_header(CMD_TYPE, 16'h0103);
    emit_body(4, 1'b1);
    wait_drain();

    // long stretch with no gaps on either side
    set_timing(16'd1, 16'd1);
    no_gaps = 1;
    random_traffic(200);
    wait_drain();
    no_gaps = 0;

    // zero settings behave as one
    set_timing(16'd0, 16'd0);
    random_traffic(100);
    wait_drain();

    // receiver holds off while the sender keeps offering words
    set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 9)));
    rx_hold_go = 1;
    random_traffic(200);
    wait_drain();

    set_timing(16'd2, 16'hFFFF);
    random_traffic(100);
    wait_drain();

    set_timing(16'hFFFF, 16'd1);
    random_traffic(100);
    wait_drain();

    // longest length the header allows, cut short after the command bytes
    set_timing(16'hFFFF, 16'hFFFF);
    make_cmd_body(2, 1, 0);
    prepend_header(CMD_TYPE, 16'hFFFF);
    emit_body(body_q.size(), 1'b1);
    push_ticks(4);
    wait_drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("relay_command_frame_sequencer_top verification clean");
    else
      $display("relay_command_frame_sequencer_top verification failed");
    $finish;
  end

endmodule
